@@ rtl/vcs_pkg.sv @@
// Package for the velocity command smoother: field widths, codes, reset values
// and the command/status structs between controller and datapath.
// No dependencies.
package vcs_pkg;

	localparam int VelW   = 24;
	localparam int LimW   = 23;
	localparam int TimeW  = 32;
	localparam int DiffW  = VelW + 1;
	localparam int ProdW  = LimW + DiffW;
	localparam int IdxW   = 4;

	localparam int GapSlotsDef     = 5;
	localparam int StaleCapUsDef   = 500000;
	localparam int DefaultGapUsDef = 100000;

	// Input kinds carried on s_tuser
	localparam logic [1:0] MODE_CMD  = 2'd0;
	localparam logic [1:0] MODE_ODOM = 2'd1;
	localparam logic [1:0] MODE_ECHO = 2'd2;
	localparam logic [1:0] MODE_TICK = 2'd3;

	// Result events carried on m_tuser
	localparam logic [1:0] EV_NORMAL = 2'd0;
	localparam logic [1:0] EV_STALE  = 2'd1;
	localparam logic [1:0] EV_ADOPT  = 2'd2;

	// Feedback source codes
	localparam logic [1:0] FB_NONE = 2'd0;
	localparam logic [1:0] FB_ODOM = 2'd1;
	localparam logic [1:0] FB_ECHO = 2'd2;

	// Register indexes
	localparam logic [IdxW-1:0] REG_LIM_X   = 4'd0;
	localparam logic [IdxW-1:0] REG_LIM_Y   = 4'd1;
	localparam logic [IdxW-1:0] REG_LIM_W   = 4'd2;
	localparam logic [IdxW-1:0] REG_ACC_LIN = 4'd3;
	localparam logic [IdxW-1:0] REG_DEC_LIN = 4'd4;
	localparam logic [IdxW-1:0] REG_ACC_W   = 4'd5;
	localparam logic [IdxW-1:0] REG_DEC_W   = 4'd6;
	localparam logic [IdxW-1:0] REG_FB_SRC  = 4'd7;

	localparam logic [LimW-1:0] RST_LIM_X   = 23'd65536;
	localparam logic [LimW-1:0] RST_LIM_Y   = 23'd39322;
	localparam logic [LimW-1:0] RST_LIM_W   = 23'd327680;
	localparam logic [LimW-1:0] RST_ACC_LIN = 23'd1638;
	localparam logic [LimW-1:0] RST_DEC_LIN = 23'd1638;
	localparam logic [LimW-1:0] RST_ACC_W   = 23'd8192;
	localparam logic [LimW-1:0] RST_DEC_W   = 23'd8192;

	typedef struct packed {
		logic cap;    // capture the accepted item
		logic cmd_wr; // raw command: ring, target
		logic fb_wr;  // feedback store
		logic med;    // one median candidate
		logic chk;    // stale / adoption check
		logic prep;   // increments, limits, products
		logic cmp;    // coupling decision, divider load
		logic div;    // one quotient bit
		logic fin;    // step outputs, load result
	} vcs_cmd_t;

	typedef struct packed {
		logic med_done;
		logic res_none;
		logic div_need;
		logic div_last;
		logic out_busy;
	} vcs_sts_t;

endpackage

@@ rtl/vcs_ctrl.sv @@
// Controller state machine of the velocity command smoother.
// Depends on vcs_pkg; drives vcs_dp through vcs_cmd_t and reads vcs_sts_t.
module vcs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [1:0]       in_mode,
	output logic             in_ready,
	input  vcs_pkg::vcs_sts_t sts,
	output vcs_pkg::vcs_cmd_t cmd
);
	import vcs_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CMD, ST_MED, ST_FB, ST_CHK, ST_PREP, ST_CMP, ST_DIV, ST_FIN
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == ST_IDLE);

	// Decode commands from the state
	always_comb begin
		cmd        = '0;
		cmd.cap    = (state_q == ST_IDLE) && in_valid;
		cmd.cmd_wr = (state_q == ST_CMD);
		cmd.fb_wr  = (state_q == ST_FB);
		cmd.med    = (state_q == ST_MED);
		cmd.chk    = (state_q == ST_CHK);
		cmd.prep   = (state_q == ST_PREP);
		cmd.cmp    = (state_q == ST_CMP);
		cmd.div    = (state_q == ST_DIV);
		cmd.fin    = (state_q == ST_FIN) && !sts.out_busy;
	end

	// Sequence one item at a time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						unique case (in_mode)
							MODE_CMD:             state_q <= ST_CMD;
							MODE_ODOM, MODE_ECHO: state_q <= ST_FB;
							MODE_TICK:            state_q <= ST_CHK;
							default:              state_q <= ST_IDLE;
						endcase
					end
				end
				ST_CMD:  state_q <= ST_MED;
				ST_MED:  if (sts.med_done) state_q <= ST_IDLE;
				ST_FB:   state_q <= ST_IDLE;
				ST_CHK:  state_q <= ST_PREP;
				ST_PREP: state_q <= ST_CMP;
				ST_CMP: begin
					if (sts.res_none)      state_q <= ST_IDLE;
					else if (sts.div_need) state_q <= ST_DIV;
					else                   state_q <= ST_FIN;
				end
				ST_DIV:  if (sts.div_last) state_q <= ST_FIN;
				ST_FIN:  if (!sts.out_busy) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/vcs_dp.sv @@
// Datapath of the velocity command smoother: registers, gap ring and median
// search, tick arithmetic, serial divider and the output register.
// Depends on vcs_pkg; controlled by vcs_ctrl.
module vcs_dp #(
	parameter int GAP_SLOTS      = vcs_pkg::GapSlotsDef,
	parameter int STALE_CAP_US   = vcs_pkg::StaleCapUsDef,
	parameter int DEFAULT_GAP_US = vcs_pkg::DefaultGapUsDef
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [1:0]                    in_mode,
	input  logic [vcs_pkg::TimeW-1:0]     in_time,
	input  logic signed [vcs_pkg::VelW-1:0] in_vx,
	input  logic signed [vcs_pkg::VelW-1:0] in_vy,
	input  logic signed [vcs_pkg::VelW-1:0] in_vw,
	input  logic                          cfg_wr,
	input  logic [vcs_pkg::IdxW-1:0]      cfg_idx,
	input  logic [vcs_pkg::LimW-1:0]      cfg_val,
	input  vcs_pkg::vcs_cmd_t             cmd,
	output vcs_pkg::vcs_sts_t             sts,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [vcs_pkg::VelW-1:0] out_x,
	output logic signed [vcs_pkg::VelW-1:0] out_y,
	output logic signed [vcs_pkg::VelW-1:0] out_w,
	output logic [1:0]                    out_ev
);
	import vcs_pkg::*;

	localparam int CntW  = $clog2(GAP_SLOTS + 1);
	localparam int RIdxW = $clog2(GAP_SLOTS);
	localparam int QW    = LimW;
	localparam int DCntW = $clog2(QW);

	// Configuration registers
	logic [LimW-1:0] lim_x_q, lim_y_q, lim_w_q, acc_l_q, dec_l_q, acc_w_q, dec_w_q;
	logic [1:0]      fb_src_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_x_q  <= RST_LIM_X;
			lim_y_q  <= RST_LIM_Y;
			lim_w_q  <= RST_LIM_W;
			acc_l_q  <= RST_ACC_LIN;
			dec_l_q  <= RST_DEC_LIN;
			acc_w_q  <= RST_ACC_W;
			dec_w_q  <= RST_DEC_W;
			fb_src_q <= FB_NONE;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_LIM_X:   lim_x_q  <= cfg_val;
				REG_LIM_Y:   lim_y_q  <= cfg_val;
				REG_LIM_W:   lim_w_q  <= cfg_val;
				REG_ACC_LIN: acc_l_q  <= cfg_val;
				REG_DEC_LIN: dec_l_q  <= cfg_val;
				REG_ACC_W:   acc_w_q  <= cfg_val;
				REG_DEC_W:   dec_w_q  <= cfg_val;
				REG_FB_SRC:  fb_src_q <= cfg_val[1:0];
				default: ;
			endcase
		end
	end

	// Captured input item
	logic [1:0]              mode_q;
	logic [TimeW-1:0]        time_q;
	logic signed [VelW-1:0]  vx_q, vy_q, vw_q;

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			mode_q <= in_mode;
			time_q <= in_time;
			vx_q   <= in_vx;
			vy_q   <= in_vy;
			vw_q   <= in_vw;
		end
	end

	function automatic logic signed [VelW-1:0] clamp_lim(logic signed [VelW-1:0] v,
			logic [LimW-1:0] lim);
		logic signed [VelW:0] vv, l;
		vv = {v[VelW-1], v};
		l  = $signed({2'b00, lim});
		if (vv > 0) return (vv < l) ? v : VelW'(l);
		return (vv > -l) ? v : VelW'(-l);
	endfunction

	function automatic logic outside(logic signed [VelW-1:0] fb, logic signed [VelW-1:0] last,
			logic [LimW-1:0] dec, logic [LimW-1:0] acc);
		logic signed [VelW+2:0] lo, hi, f;
		f  = {{3{fb[VelW-1]}}, fb};
		lo = {{3{last[VelW-1]}}, last} - $signed({3'b000, dec, 1'b0});
		hi = {{3{last[VelW-1]}}, last} + $signed({3'b000, acc, 1'b0});
		return (f < lo) || (f > hi);
	endfunction

	// Smoother state
	logic signed [VelW-1:0] tgt_q [3];
	logic signed [VelW-1:0] last_q [3];
	logic signed [VelW-1:0] fb_q [3];
	logic [TimeW-1:0]       ring_q [GAP_SLOTS];
	logic [CntW-1:0]        gcnt_q;
	logic [RIdxW-1:0]       gnext_q, midx_q;
	logic [TimeW-1:0]       ltime_q, avg_q;
	logic                   active_q;
	logic [1:0]             ev_q;

	// Median candidate ranking over the known gaps
	logic [TimeW-1:0] cand;
	logic [CntW-1:0]  n_less, n_leq, half;
	logic             found, few;

	always_comb begin
		cand   = ring_q[midx_q];
		n_less = '0;
		n_leq  = '0;
		for (int j = 0; j < GAP_SLOTS; j++) begin
			if (CntW'(j) < gcnt_q) begin
				n_less = n_less + CntW'(ring_q[j] < cand);
				n_leq  = n_leq + CntW'(ring_q[j] <= cand);
			end
		end
		half  = gcnt_q >> 1;
		found = (n_less <= half) && (half < n_leq);
		few   = (gcnt_q <= CntW'(GAP_SLOTS / 2));
	end

	// Stale and adoption checks
	logic [TimeW-1:0]   elapsed;
	logic [TimeW+1:0]   avg3, cap3;
	logic [TimeW+2:0]   avg5;
	logic               stale, act_n, adopt;

	always_comb begin
		elapsed = time_q - ltime_q;
		avg3    = {2'b00, avg_q} + {1'b0, avg_q, 1'b0};
		cap3    = (avg3 > (TimeW+2)'(STALE_CAP_US)) ? (TimeW+2)'(STALE_CAP_US) : avg3;
		avg5    = {3'b000, avg_q} + {1'b0, avg_q, 2'b00};
		stale   = active_q && (avg_q != '0) && ({2'b00, elapsed} > cap3);
		act_n   = active_q && !stale;
		adopt   = ((fb_src_q == FB_ODOM) || (fb_src_q == FB_ECHO)) && act_n
			&& (avg_q != '0) && (({3'b000, elapsed} > avg5)
			|| outside(fb_q[0], last_q[0], dec_l_q, acc_l_q)
			|| outside(fb_q[2], last_q[2], dec_w_q, acc_w_q));
	end

	// Increments and per-axis limits
	logic signed [DiffW-1:0] dif [3];
	logic [DiffW-1:0]        mag [3];
	logic [LimW-1:0]         alim [3];
	logic                    neq;

	always_comb begin
		neq = 1'b0;
		for (int a = 0; a < 3; a++) begin
			dif[a] = {tgt_q[a][VelW-1], tgt_q[a]} - {last_q[a][VelW-1], last_q[a]};
			mag[a] = dif[a][DiffW-1] ? DiffW'(-dif[a]) : DiffW'(dif[a]);
			if (tgt_q[a] != last_q[a]) neq = 1'b1;
		end
		for (int a = 0; a < 3; a++) begin
			if ((fb_src_q == FB_ODOM) && (((fb_q[a] > 0) && (tgt_q[a] < 0))
					|| ((fb_q[a] < 0) && (tgt_q[a] > 0))))
				alim[a] = (a == 2) ? dec_w_q : dec_l_q;
			else if (((dif[a] > 0) && (tgt_q[a] > 0)) || ((dif[a] < 0) && (tgt_q[a] < 0)))
				alim[a] = (a == 2) ? acc_w_q : acc_l_q;
			else
				alim[a] = (a == 2) ? dec_w_q : dec_l_q;
		end
	end

	// Coupling operands registered after the multipliers
	logic [LimW-1:0]  mx_q, my_q, mw_q;
	logic [DiffW-1:0] ax_q, aw_q;
	logic [ProdW-1:0] p1_q, p2_q;
	logic             neq_q, selx_q, selw_q;

	// Serial restoring divider, one quotient bit per cycle
	logic [DiffW-1:0] rem_q, dvs_q;
	logic [QW-1:0]    low_q;
	logic [DCntW-1:0] dcnt_q;
	logic [DiffW:0]   trial;
	logic             ge;

	always_comb begin
		trial = {rem_q, low_q[QW-1]} - {1'b0, dvs_q};
		ge    = ({rem_q, low_q[QW-1]} >= {1'b0, dvs_q});
	end

	// Step each axis toward the target
	logic [LimW-1:0]        flim [3];
	logic signed [VelW-1:0] stepv [3];

	always_comb begin
		flim[0] = selx_q ? low_q : mx_q;
		flim[1] = my_q;
		flim[2] = selw_q ? low_q : mw_q;
		for (int a = 0; a < 3; a++) begin
			if (mag[a] > {2'b00, flim[a]})
				stepv[a] = (dif[a] > 0) ? VelW'(last_q[a] + $signed({1'b0, flim[a]}))
					: VelW'(last_q[a] - $signed({1'b0, flim[a]}));
			else
				stepv[a] = tgt_q[a];
		end
	end

	// Gap ring payload
	always_ff @(posedge clk) begin
		if (cmd.cmd_wr) ring_q[gnext_q] <= time_q - ltime_q;
	end

	// Control state of the smoother
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				tgt_q[a]  <= '0;
				last_q[a] <= '0;
				fb_q[a]   <= '0;
			end
			gcnt_q    <= '0;
			gnext_q   <= '0;
			midx_q    <= '0;
			ltime_q   <= '0;
			avg_q     <= '0;
			active_q  <= 1'b0;
			ev_q      <= EV_NORMAL;
			out_valid <= 1'b0;
			selx_q    <= 1'b0;
			selw_q    <= 1'b0;
			dcnt_q    <= '0;
		end else begin
			if (cmd.cmd_wr) begin
				gnext_q  <= (gnext_q == RIdxW'(GAP_SLOTS - 1)) ? '0 : gnext_q + 1'b1;
				if (gcnt_q < CntW'(GAP_SLOTS)) gcnt_q <= gcnt_q + 1'b1;
				ltime_q  <= time_q;
				active_q <= 1'b1;
				midx_q   <= '0;
				tgt_q[0] <= clamp_lim(vx_q, lim_x_q);
				tgt_q[1] <= clamp_lim(vy_q, lim_y_q);
				tgt_q[2] <= clamp_lim(vw_q, lim_w_q);
			end
			if (cmd.med) begin
				if (few)        avg_q <= TimeW'(DEFAULT_GAP_US);
				else if (found) avg_q <= cand;
				else            midx_q <= midx_q + 1'b1;
			end
			if (cmd.fb_wr && (fb_src_q == mode_q)) begin
				fb_q[0] <= vx_q;
				fb_q[1] <= vy_q;
				fb_q[2] <= vw_q;
			end
			if (cmd.chk) begin
				active_q <= act_n;
				ev_q     <= adopt ? EV_ADOPT : (stale ? EV_STALE : EV_NORMAL);
				for (int a = 0; a < 3; a++) begin
					if (adopt)      tgt_q[a] <= fb_q[a];
					else if (stale) tgt_q[a] <= '0;
				end
			end
			if (cmd.cmp) begin
				selx_q <= (p1_q < p2_q);
				selw_q <= !(p1_q < p2_q) && (ax_q != '0);
				dcnt_q <= '0;
			end
			if (cmd.div) dcnt_q <= dcnt_q + 1'b1;
			if (cmd.fin) begin
				for (int a = 0; a < 3; a++) last_q[a] <= stepv[a];
			end
			// Load on a finishing step, drop on the output transfer
			if (cmd.fin)
				out_valid <= 1'b1;
			else if (out_valid && out_ready)
				out_valid <= 1'b0;
		end
	end

	// Registered multiplier products and divider data
	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			mx_q  <= alim[0];
			my_q  <= alim[1];
			mw_q  <= alim[2];
			ax_q  <= mag[0];
			aw_q  <= mag[2];
			neq_q <= neq;
			p1_q  <= ProdW'(alim[2] * mag[0]);
			p2_q  <= ProdW'(mag[2] * alim[0]);
		end
		if (cmd.cmp) begin
			if (p1_q < p2_q) begin
				rem_q <= p1_q[ProdW-1:QW];
				low_q <= p1_q[QW-1:0];
				dvs_q <= aw_q;
			end else begin
				rem_q <= p2_q[ProdW-1:QW];
				low_q <= p2_q[QW-1:0];
				dvs_q <= ax_q;
			end
		end
		if (cmd.div) begin
			rem_q <= ge ? trial[DiffW-1:0] : {rem_q[DiffW-2:0], low_q[QW-1]};
			low_q <= {low_q[QW-2:0], ge};
		end
		if (cmd.fin) begin
			out_x  <= stepv[0];
			out_y  <= stepv[1];
			out_w  <= stepv[2];
			out_ev <= ev_q;
		end
	end

	always_comb begin
		sts.med_done = few || found;
		sts.res_none = !neq_q && !active_q;
		sts.div_need = (p1_q < p2_q) || (ax_q != '0);
		sts.div_last = (dcnt_q == DCntW'(QW - 1));
		sts.out_busy = out_valid && !out_ready;
	end

endmodule

@@ rtl/velocity_command_smoother_top.sv @@
// Top level of the velocity command smoother: stream ports, configuration port,
// controller (vcs_ctrl) and datapath (vcs_dp). Depends on vcs_pkg.
//
// Takes one item at a time. A raw command passes through the ring write state and
// then the median search over the gap ring, which steps through candidates once
// more than GAP_SLOTS/2 gaps are known; a feedback item passes through the store
// state. A control tick passes through the check, prepare and compare states, then
// the serial divider when the x/turn coupling rescales a limit, and the finishing
// step unless it gives no result; the divider is the long pole. One result waits
// in the output register while the next item is accepted; a tick stalls only while
// that result is still waiting. The configuration port is always ready.
module velocity_command_smoother_top #(
	parameter int GAP_SLOTS      = vcs_pkg::GapSlotsDef,
	parameter int STALE_CAP_US   = vcs_pkg::StaleCapUsDef,
	parameter int DEFAULT_GAP_US = vcs_pkg::DefaultGapUsDef
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [103:0]              s_tdata,  // time_us, vel_x, vel_y, vel_turn
	input  logic [1:0]                s_tuser,  // mode
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [71:0]               m_tdata,  // out_x, out_y, out_turn
	output logic [1:0]                m_tuser,  // event_res
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [vcs_pkg::IdxW-1:0]  cfg_index,
	input  logic [vcs_pkg::LimW-1:0]  cfg_data
);
	import vcs_pkg::*;

	vcs_cmd_t cmd;
	vcs_sts_t sts;
	logic signed [VelW-1:0] ox, oy, ow;

	assign cfg_ready = 1'b1;
	assign m_tdata   = {ow, oy, ox};

	vcs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_mode  (s_tuser),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	vcs_dp #(
		.GAP_SLOTS      (GAP_SLOTS),
		.STALE_CAP_US   (STALE_CAP_US),
		.DEFAULT_GAP_US (DEFAULT_GAP_US)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_mode   (s_tuser),
		.in_time   (s_tdata[31:0]),
		.in_vx     (s_tdata[55:32]),
		.in_vy     (s_tdata[79:56]),
		.in_vw     (s_tdata[103:80]),
		.cfg_wr    (cfg_valid && cfg_ready),
		.cfg_idx   (cfg_index),
		.cfg_val   (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_x     (ox),
		.out_y     (oy),
		.out_w     (ow),
		.out_ev    (m_tuser)
	);

	// A new result appears only after a finishing step
	a_rise_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(cmd.fin))
		else $error("result without finishing step");

	// The divider never runs while the block takes input
	a_idle_no_div: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !cmd.div)
		else $error("divider active while idle");

	// The finishing step never overwrites a waiting result
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> !(m_tvalid && !m_tready))
		else $error("result overwritten");

	// Event codes stay within the defined set
	a_event_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == EV_NORMAL || m_tuser == EV_STALE || m_tuser == EV_ADOPT))
		else $error("bad event code");

endmodule
